@@ hw/rtl/slcf_pkg.sv @@
package slcf_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int ROW_W       = 10;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CFG_COL_W   = COL_W + 1;
   localparam int COUNT_W     = 11;
   localparam int SUM_W       = COUNT_W + COL_W;
   localparam int COST_W      = SUM_W + 1;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
   localparam logic [CFG_COL_W-1:0] COLUMNS_LIMIT  = CFG_COL_W'(MAX_COLUMNS);
   localparam logic [COL_W-1:0]     LAST_COLUMN    = COL_W'(MAX_COLUMNS - 1);

   localparam logic [1:0] REG_ROW_START    = 2'd0;
   localparam logic [1:0] REG_ROW_END      = 2'd1;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             wall_mark;
      logic             free_mark;
      logic             last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [COL_W-1:0] right_column;
      logic [COL_W-1:0] left_column;
   } result_type;

endpackage

@@ hw/rtl/side_line_column_finder.sv @@
// Counts wall pixels per column over a configurable row band, then picks the
// best right-side and left-side line columns. Pixels come in column-major
// order, one transaction each time start is high while busy is low; for each
// pixel its column count is read from and then written back to the count
// memory. After the pixel flagged last, the block scans the counts right to
// left and then left to right through one shared add-and-compare unit at one
// column a cycle; the second scan also clears the counts for the next image.
// After reset busy stays high for a clearing pass over the whole count
// memory. The single result is shown on the rsp_ ports for exactly one cycle,
// marked by rsp_strobe, and cannot be held off by the receiver.
module side_line_column_finder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  slcf_pkg::pixel_type                 req_pixel,
   output logic                                rsp_strobe,
   output slcf_pkg::result_type                rsp_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [slcf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [slcf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [slcf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import slcf_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_COUNT = 6'b000100,
      ST_RSCAN = 6'b001000,
      ST_REND  = 6'b010000,
      ST_LSCAN = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [ROW_W-1:0]     row_start_ff;
   logic [CFG_COL_W-1:0] row_end_ff;
   logic [CFG_COL_W-1:0] column_count_ff;
   logic                 csr_write;
   logic [CFG_COL_W-1:0] used_columns;
   logic [COL_W-1:0]     last_used;

   logic [COUNT_W-1:0] count_mem [MAX_COLUMNS];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [COL_W-1:0]   rd_addr;
   logic               wr_en;
   logic [COL_W-1:0]   wr_addr;
   logic [COUNT_W-1:0] wr_data;

   logic [COL_W-1:0] addr_ff, addr_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             inc_ff, inc_in;
   logic             last_ff, last_in;
   logic             qualify;

   logic              proc_ff, proc_in;
   logic [COL_W-1:0]  proc_col_ff, proc_col_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [COST_W-1:0] best_cost_ff, best_cost_in;
   logic [COL_W-1:0]  best_col_ff, best_col_in;
   logic signed [COST_W-1:0] cost;
   logic              take;
   logic [COL_W-1:0]  best_col_next;
   logic              scan_rst;

   logic [COL_W-1:0] right_ff, right_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   result_type       rsp_result_ff, rsp_result_in;

   // the left scan has issued its last read once the unit holds the last column
   function automatic logic rd_en_pending(input logic [COL_W-1:0] addr,
                                          input logic [COL_W-1:0] last,
                                          input logic [COL_W-1:0] pcol);
      return !(pcol == last && addr == last);
   endfunction

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_start_ff    <= '0;
         row_end_ff      <= COLUMNS_LIMIT;
         column_count_ff <= COLUMNS_LIMIT;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_ROW_START:    row_start_ff    <= pwdata[ROW_W-1:0];
            REG_ROW_END:      row_end_ff      <= pwdata[CFG_COL_W-1:0];
            REG_COLUMN_COUNT: column_count_ff <= pwdata[CFG_COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ROW_START:    prdata = CSR_DATA_W'(row_start_ff);
         REG_ROW_END:      prdata = CSR_DATA_W'(row_end_ff);
         REG_COLUMN_COUNT: prdata = CSR_DATA_W'(column_count_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (column_count_ff == '0) begin
         used_columns = CFG_COL_W'(1);
      end else if (column_count_ff > COLUMNS_LIMIT) begin
         used_columns = COLUMNS_LIMIT;
      end else begin
         used_columns = column_count_ff;
      end
   end
   assign last_used = COL_W'(used_columns - CFG_COL_W'(1));

   assign qualify = (CFG_COL_W'(req_pixel.column) < used_columns)
                  && (req_pixel.row >= row_start_ff)
                  && (CFG_COL_W'(req_pixel.row) < row_end_ff)
                  && req_pixel.wall_mark && !req_pixel.free_mark;

   // count memory
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_addr];
      end
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
   end

   // shared add and compare unit
   assign cost = $signed({{(COST_W-COUNT_W){1'b0}}, rd_data_ff})
               - $signed({1'b0, sum_ff});
   assign take = proc_ff && (cost >= best_cost_ff);
   assign best_col_next = take ? proc_col_ff : best_col_ff;

   always_comb begin
      if (scan_rst) begin
         sum_in       = '0;
         best_cost_in = -COST_W'(1);
         best_col_in  = '0;
      end else if (proc_ff) begin
         sum_in       = sum_ff + SUM_W'(rd_data_ff);
         best_cost_in = take ? cost : best_cost_ff;
         best_col_in  = best_col_next;
      end else begin
         sum_in       = sum_ff;
         best_cost_in = best_cost_ff;
         best_col_in  = best_col_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      col_in        = col_ff;
      inc_in        = inc_ff;
      last_in       = last_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;
      proc_in       = 1'b0;
      proc_col_in   = addr_ff;
      scan_rst      = 1'b0;
      right_in      = right_ff;
      rsp_strobe_in = 1'b0;
      rsp_result_in = rsp_result_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_COLUMN) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + COL_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               rd_en    = 1'b1;
               rd_addr  = req_pixel.column;
               col_in   = req_pixel.column;
               inc_in   = qualify;
               last_in  = req_pixel.last_pixel;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            wr_addr = col_ff;
            wr_data = rd_data_ff + COUNT_W'(1);
            wr_en   = inc_ff && (rd_data_ff != COUNT_MAX);
            if (last_ff) begin
               scan_rst = 1'b1;
               addr_in  = last_used;
               state_in = ST_RSCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RSCAN: begin
            rd_en   = 1'b1;
            proc_in = 1'b1;
            if (addr_ff == '0) begin
               state_in = ST_REND;
            end else begin
               addr_in = addr_ff - COL_W'(1);
            end
         end
         ST_REND: begin
            right_in = best_col_next;
            scan_rst = 1'b1;
            addr_in  = '0;
            state_in = ST_LSCAN;
         end
         ST_LSCAN: begin
            // read each count once more and clear it behind the read
            if (proc_ff && !rd_en_pending(addr_ff, last_used, proc_col_ff)) begin
               rsp_strobe_in              = 1'b1;
               rsp_result_in.right_column = right_ff;
               rsp_result_in.left_column  = best_col_next;
               scan_rst                   = 1'b1;
               state_in                   = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               wr_en   = 1'b1;
               proc_in = 1'b1;
               if (addr_ff != last_used) begin
                  addr_in = addr_ff + COL_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         proc_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         inc_ff        <= 1'b0;
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         proc_ff       <= proc_in;
         rsp_strobe_ff <= rsp_strobe_in;
         inc_ff        <= inc_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      proc_col_ff   <= proc_col_in;
      sum_ff        <= sum_in;
      best_cost_ff  <= best_cost_in;
      best_col_ff   <= best_col_in;
      right_ff      <= right_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result = rsp_result_ff;

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_LSCAN))
      else $error("result strobe without a finished left scan");

   a_count_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && wr_en) |-> (rd_data_ff != COUNT_MAX))
      else $error("column count wrapped");

   a_proc_in_scan: assert property (@(posedge clock) disable iff (reset)
      proc_ff |-> (state_ff == ST_RSCAN || state_ff == ST_REND || state_ff == ST_LSCAN))
      else $error("scan unit active outside a scan");

   a_accept_counts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_COUNT))
      else $error("accepted pixel not counted");

endmodule
